### design/i64da_pkg.sv
// ---------------------------------------------------------------------------
// i64da_pkg
// shared types and constants for the signed 64-bit to decimal text converter
// ---------------------------------------------------------------------------
package i64da_pkg;

    localparam int VALUE_W    = 64;
    localparam int CHAR_W     = 6;
    localparam int NUM_DIGITS = 20;
    localparam int BCD_W      = NUM_DIGITS * 4;
    localparam int BITS_PER_STEP = 2;
    localparam int NUM_STEPS  = VALUE_W / BITS_PER_STEP;
    localparam int STEP_W     = $clog2(NUM_STEPS);
    localparam int IDX_W      = $clog2(NUM_DIGITS);

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = CHAR_W'(48);
    localparam logic [CHAR_W-1:0] CHAR_MINUS = CHAR_W'(45);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_MEASURE,
        ST_SIGN,
        ST_DIGITS
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic measure;
        logic next_digit;
        logic show_sign;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic step_last;
        logic negative;
        logic final_digit;
    } status_t;

endpackage

### design/int64_to_decimal_ascii.sv
// ---------------------------------------------------------------------------
// int64_to_decimal_ascii
// signed 64-bit integer to decimal ascii text, one character per transfer
// ---------------------------------------------------------------------------
// Each input transfer carries one two's complement 64-bit value. The block
// answers with its decimal text on the master side, one ascii character per
// transfer, most significant first: a leading '-' for negative values, no
// leading zeros, a single '0' for zero, tlast on the final character. The
// most negative value gives '-' and 19 digits. One number is handled at a
// time: after the accept the double-dabble converter takes in two magnitude
// bits per cycle, then the length is measured, and the n characters (1 to
// 20) follow at one per cycle when the sink is ready. s_tready is high only
// between numbers.
// ---------------------------------------------------------------------------
module int64_to_decimal_ascii import i64da_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    // input channel
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic signed [63:0]  s_tdata,   // [63:0] value
    // result channel
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,   // [5:0] character, [7:6] zero
    output logic                m_tlast    // final character of the number
);

    cmd_t              cmd;
    status_t           status;
    logic [CHAR_W-1:0] character;
    logic              last;

    // sequencer
    i64da_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    // magnitude and bcd datapath
    i64da_dp u_dp (
        .aclk      (aclk),
        .value     (VALUE_W'(s_tdata)),
        .cmd       (cmd),
        .status    (status),
        .character (character),
        .last      (last)
    );

    // characters come straight from registered state
    assign m_tdata = {2'b00, character};
    assign m_tlast = last;

endmodule

### design/i64da_ctrl.sv
// ---------------------------------------------------------------------------
// i64da_ctrl
// sequencer: accept, convert, measure length, stream sign and digits
// ---------------------------------------------------------------------------
module i64da_ctrl import i64da_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) state_next = ST_CONVERT;
            end
            ST_CONVERT: begin
                if (status.step_last) state_next = ST_MEASURE;
            end
            ST_MEASURE: begin
                state_next = status.negative ? ST_SIGN : ST_DIGITS;
            end
            ST_SIGN: begin
                if (out_ready) state_next = ST_DIGITS;
            end
            ST_DIGITS: begin
                if (out_ready && status.final_digit) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
        cmd       = '0;
        case (state_reg)
            ST_IDLE: begin
                // nothing is taken while reset is held
                in_ready = aresetn;
                cmd.load = in_valid && aresetn;
            end
            ST_CONVERT: begin
                cmd.step = 1'b1;
            end
            ST_MEASURE: begin
                cmd.measure = 1'b1;
            end
            ST_SIGN: begin
                out_valid     = 1'b1;
                cmd.show_sign = 1'b1;
            end
            ST_DIGITS: begin
                out_valid      = 1'b1;
                cmd.next_digit = out_ready;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

### design/i64da_dp.sv
// ---------------------------------------------------------------------------
// i64da_dp
// magnitude, double-dabble bcd register and character selection
// ---------------------------------------------------------------------------
module i64da_dp import i64da_pkg::*; (
    input  logic              aclk,
    input  logic [VALUE_W-1:0] value,
    input  cmd_t              cmd,
    output status_t           status,
    output logic [CHAR_W-1:0] character,
    output logic              last
);

    logic [VALUE_W-1:0] mag_reg, mag_next;
    logic [BCD_W-1:0]   bcd_reg, bcd_next;
    logic               neg_reg, neg_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [IDX_W-1:0]   top_idx;
    logic [3:0]         digit;

    // one shift-and-add-3 step
    function automatic logic [BCD_W-1:0] dd_step(input logic [BCD_W-1:0] bcd_in,
                                                 input logic bit_in);
        logic [BCD_W-1:0] adj;
        adj = bcd_in;
        for (int d = 0; d < NUM_DIGITS; d++) begin
            if (bcd_in[d*4 +: 4] >= 4'd5) adj[d*4 +: 4] = bcd_in[d*4 +: 4] + 4'd3;
        end
        return {adj[BCD_W-2:0], bit_in};
    endfunction

    // highest non-zero digit, zero when the whole number is zero
    always_comb begin
        top_idx = '0;
        for (int d = 1; d < NUM_DIGITS; d++) begin
            if (bcd_reg[d*4 +: 4] != 4'd0) top_idx = IDX_W'(d);
        end
    end

    always_comb begin
        mag_next  = mag_reg;
        bcd_next  = bcd_reg;
        neg_next  = neg_reg;
        step_next = step_reg;
        idx_next  = idx_reg;
        if (cmd.load) begin
            neg_next  = value[VALUE_W-1];
            mag_next  = value[VALUE_W-1] ? (~value + VALUE_W'(1)) : value;
            bcd_next  = '0;
            step_next = '0;
        end else if (cmd.step) begin
            bcd_next  = dd_step(dd_step(bcd_reg, mag_reg[VALUE_W-1]), mag_reg[VALUE_W-2]);
            mag_next  = {mag_reg[VALUE_W-BITS_PER_STEP-1:0], BITS_PER_STEP'(0)};
            step_next = step_reg + STEP_W'(1);
        end else if (cmd.measure) begin
            idx_next = top_idx;
        end else if (cmd.next_digit) begin
            idx_next = idx_reg - IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        mag_reg  <= mag_next;
        bcd_reg  <= bcd_next;
        neg_reg  <= neg_next;
        step_reg <= step_next;
        idx_reg  <= idx_next;
    end

    assign digit = bcd_reg[idx_reg*4 +: 4];

    assign status.step_last   = (step_reg == STEP_W'(NUM_STEPS - 1));
    assign status.negative    = neg_reg;
    assign status.final_digit = (idx_reg == '0);

    assign character = cmd.show_sign ? CHAR_MINUS : (CHAR_ZERO + {2'b00, digit});
    assign last      = !cmd.show_sign && (idx_reg == '0);

endmodule

### design/i64da_checker.sv
// ---------------------------------------------------------------------------
// i64da_checker
// port-level checks on the decimal text converter
// ---------------------------------------------------------------------------
module i64da_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [63:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tlast
);

    // a stalled transfer keeps its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result payload changed while stalled");

    // one number at a time
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while a result is offered");

    // conversion takes time after an accept
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !m_tvalid)
        else $error("result offered straight after accept");

    // only minus sign or decimal digits
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata == 8'd45) || (m_tdata == 8'd48) || (m_tdata == 8'd49) ||
                     (m_tdata == 8'd50) || (m_tdata == 8'd51) || (m_tdata == 8'd52) ||
                     (m_tdata == 8'd53) || (m_tdata == 8'd54) || (m_tdata == 8'd55) ||
                     (m_tdata == 8'd56) || (m_tdata == 8'd57))
        else $error("character out of range");

    // after the final character the block is free again
    a_release: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=> s_tready && !m_tvalid)
        else $error("block not idle after final character");

endmodule

bind int64_to_decimal_ascii i64da_checker u_i64da_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

### bench/int64_to_decimal_ascii_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// int64_to_decimal_ascii_tb
// self-checking bench for the signed 64-bit to decimal text converter
// ---------------------------------------------------------------------------
// Values go in on the slave side, first a directed set (zero, one, the
// extremes, digit-count boundaries on both signs), then random values spread
// over every digit count. A tracker works out the expected character string
// of each accepted value and compares every master-side transfer against the
// oldest pending character. Both sides idle in random bursts, the sink holds
// off once for a long stretch while values keep coming, and the source waits
// for the block to drain between phases.
// ---------------------------------------------------------------------------
module int64_to_decimal_ascii_tb import i64da_pkg::*; ();

    localparam int  DIRECTED_COUNT = 18;
    localparam int  RANDOM_COUNT   = 156;
    localparam int  CALM_TAIL      = 30;     // last random values with no idling
    localparam int  LONG_HOLD      = 400;    // sink hold-off in cycles
    localparam int  SETTLE_CYCLES  = 60;     // longer than one number takes with no sink stall
    localparam int  CYCLE_LIMIT    = 400000;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } text_char_t;

    // expected text of every accepted value, oldest character first
    class decimal_text_tracker;
        text_char_t pending_chars[$];
        int         mismatches = 0;

        task report_mismatch(string what);
            mismatches++;
            $display("[%0t] MISMATCH: %s", $realtime, what);
        endtask

        // split the magnitude into decimal digits, sign first when negative
        task note_value(logic [VALUE_W-1:0] value);
            logic [VALUE_W-1:0] mag;
            logic [3:0]         digits[NUM_DIGITS];
            int                 nd;
            mag = value[VALUE_W-1] ? (~value + 64'd1) : value;
            nd  = 0;
            do begin
                digits[nd] = 4'(mag % 64'd10);
                mag        = mag / 64'd10;
                nd++;
            end while (mag != 64'd0 && nd < NUM_DIGITS);
            if (value[VALUE_W-1])
                pending_chars.push_back('{code: CHAR_MINUS, last: 1'b0});
            for (int i = nd - 1; i >= 0; i--)
                pending_chars.push_back('{code: CHAR_ZERO + CHAR_W'(digits[i]),
                                          last: (i == 0)});
        endtask

        task check_char(logic [7:0] data, logic last);
            text_char_t want;
            if (pending_chars.size() == 0) begin
                report_mismatch($sformatf("character 0x%02h with nothing pending", data));
                return;
            end
            want = pending_chars.pop_front();
            if (data[CHAR_W-1:0] !== want.code)
                report_mismatch($sformatf("character %0d, expected %0d",
                                          data[CHAR_W-1:0], want.code));
            if (data[7:CHAR_W] !== '0)
                report_mismatch($sformatf("tdata padding 0x%0h not zero", data[7:CHAR_W]));
            if (last !== want.last)
                report_mismatch($sformatf("tlast %b, expected %b", last, want.last));
        endtask
    endclass

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [VALUE_W-1:0]  s_tdata;    // [63:0] value
    logic                m_tvalid;
    logic                m_tready;
    logic [7:0]          m_tdata;    // [5:0] character, [7:6] zero
    logic                m_tlast;

    decimal_text_tracker tracker = new;

    bit  calm          = 1'b0;       // no idling on either side
    bit  sink_hold_req = 1'b0;       // ask the sink for one long hold-off
    int  cycle_count   = 0;

    int64_to_decimal_ascii i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // both channels sampled at the edge, before any driver update lands
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                tracker.note_value(s_tdata);
            if (m_tvalid && m_tready)
                tracker.check_char(m_tdata, m_tlast);
        end
    end

    // sink side: random stall bursts, one long hold-off on request
    initial begin
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (sink_hold_req) begin
                sink_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                m_tready <= 1'b1;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
            @(posedge aclk);
        end
    end

    // offer one value, hold it until the transfer, then maybe idle a burst;
    // tvalid stays high into the next value when there is no burst
    task automatic send_value(input logic [VALUE_W-1:0] value, input bit may_idle);
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do @(posedge aclk); while (!s_tready);
        if (may_idle && !calm && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= {$urandom, $urandom};
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    endtask

    // one edge first so the last accepted value is already noted
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (tracker.pending_chars.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // random value with a spread of digit counts and both signs
    function automatic logic [VALUE_W-1:0] random_value();
        logic [VALUE_W-1:0] mag;
        int                 ndig;
        case ($urandom_range(0, 3))
            0: return {$urandom, $urandom};
            1: mag = 64'($urandom_range(0, 999));
            2: begin
                // near a power of ten, crossing a digit-count boundary
                ndig = $urandom_range(1, 18);
                mag  = 64'd1;
                repeat (ndig) mag = mag * 64'd10;
                mag = mag + 64'($urandom_range(0, 2)) - 64'd1;
            end
            default: begin
                ndig = $urandom_range(1, 19);
                mag  = 64'd0;
                repeat (ndig) mag = mag * 64'd10 + 64'($urandom_range(0, 9));
                mag[63] = 1'b0;
            end
        endcase
        return $urandom_range(0, 1) ? (~mag + 64'd1) : mag;
    endfunction

    logic [VALUE_W-1:0] directed_values[DIRECTED_COUNT] = '{
        64'd0,
        64'd1,
        -64'sd1,
        64'd9,
        64'd10,
        -64'sd10,
        64'd99,
        64'd100,
        64'd12345,
        -64'sd9876543210,
        64'h7FFF_FFFF_FFFF_FFFF,          // largest positive, 19 digits
        64'h8000_0000_0000_0000,          // most negative, sign and 19 digits
        64'h8000_0000_0000_0001,
        64'd999999999999999999,
        64'd1000000000000000000,
        -64'sd1000000000000000000,
        64'h0000_0000_FFFF_FFFF,
        64'hFFFF_FFFF_0000_0000
    };

    initial begin
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed values
        foreach (directed_values[i])
            send_value(directed_values[i], 1'b1);
        wait_drained();

        // sink holds off while values keep coming, so the block backs up
        sink_hold_req = 1'b1;
        repeat (6) send_value(random_value(), 1'b0);
        wait_drained();

        // random values, idling stops for the tail
        for (int n = 0; n < RANDOM_COUNT; n++) begin
            if (n == RANDOM_COUNT - CALM_TAIL)
                calm = 1'b1;
            send_value(random_value(), 1'b1);
        end
        wait_drained();

        if (tracker.pending_chars.size() != 0)
            tracker.report_mismatch("characters still pending at the end");
        if (tracker.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
